/* rtl/gfp_pkg.sv */
// shared types and constants of the greedy flight partitioner
package gfp_pkg;

  // fixed field widths of the stream items
  localparam int NODE_W      = 6;
  localparam int DIST_IN_W   = 16;
  localparam int FT_W        = 21;
  localparam int CNT_W       = 16;
  localparam int TOT_W       = 32;
  localparam int MAXFT_W     = 20;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  localparam logic [FT_W-1:0]    FT_MAX      = '1;
  localparam logic [TOT_W-1:0]   TOT_MAX     = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [MAXFT_W-1:0] MAXFT_RESET = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PAIR_LOAD   = 2'd0,
    MODE_GROUND_LOAD = 2'd1,
    MODE_MISSION     = 2'd2,
    MODE_FINISH      = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_MISSION = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // control of the update stage entry
  typedef struct packed {
    logic              valid;
    logic              is_finish;
    logic              pp_ok;     // previous delivery and pickup both in range
    logic              gb_ok;     // previous delivery in range
    logic [NODE_W-1:0] delivery;
  } s2_entry_t;

endpackage

/* rtl/gfp_pair_mem.sv */
// node-to-node distance memory, one write port and one registered read port
module gfp_pair_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gfp_ground_mem.sv */
// ground-station distance memory, one write port and two registered read ports
module gfp_ground_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re_a,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic              re_b,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* rtl/gfp_flight_core.sv */
// update stage: flight state, next-fit decision and result register
module gfp_flight_core #(
  parameter int DIST_W = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [gfp_pkg::MAXFT_W-1:0]         max_flight_time,
  input  gfp_pkg::s2_entry_t                  s2_in,
  input  logic [DIST_W+1:0]                   fresh_in,    // fresh round trip
  input  logic [DIST_W:0]                     pdgd_in,     // mission leg plus return
  input  logic [DIST_W-1:0]                   pp_rdata,    // previous delivery to pickup
  input  logic [DIST_W-1:0]                   gb_rdata,    // old return leg
  output logic                                s2_stall,
  output logic [gfp_pkg::NODE_W-1:0]          prev_node,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic                                out_tuser,   // result_kind
  // mission_index, flight_index, opened_new_flight, flight_time, total_time
  output logic [gfp_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import gfp_pkg::*;

  localparam int SUM_W = ((DIST_W + 1 > FT_W) ? DIST_W + 1 : FT_W) + 2;

  s2_entry_t           s2_r;
  logic [DIST_W+1:0]   fresh_r;
  logic [DIST_W:0]     pdgd_r;
  logic                s2_go;

  logic [FT_W-1:0]     cur_r,    cur_nxt;
  logic [NODE_W-1:0]   prev_r,   prev_nxt;
  logic [CNT_W-1:0]    mcnt_r,   mcnt_nxt;
  logic [CNT_W-1:0]    fcnt_r,   fcnt_nxt;
  logic [TOT_W-1:0]    closed_r, closed_nxt;
  logic                active_r, active_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r,  out_kind_nxt;
  logic [CNT_W-1:0]    out_mi_r,    out_mi_nxt;
  logic [CNT_W-1:0]    out_fi_r,    out_fi_nxt;
  logic                out_open_r,  out_open_nxt;
  logic [FT_W-1:0]     out_ft_r,    out_ft_nxt;
  logic [TOT_W-1:0]    out_tot_r,   out_tot_nxt;

  logic [DIST_W-1:0]   pp;
  logic [DIST_W-1:0]   gb;
  logic [SUM_W-1:0]    cur_e;
  logic [SUM_W-1:0]    gb_e;
  logic [SUM_W-1:0]    trimmed;
  logic [SUM_W-1:0]    ext;
  logic [SUM_W-1:0]    fresh_e;
  logic                fits;
  logic [FT_W-1:0]     ext_sat;
  logic [FT_W-1:0]     fresh_sat;
  logic [TOT_W:0]      sum_wide;
  logic [TOT_W-1:0]    sum_sat;

  assign s2_stall  = s2_r.valid && out_valid_r && !out_tready;
  assign s2_go     = s2_r.valid && !s2_stall;
  assign prev_node = prev_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (!s2_stall) begin
      s2_r <= s2_in;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_in.valid && !s2_stall) begin
      fresh_r <= fresh_in;
      pdgd_r  <= pdgd_in;
    end
  end

  // extension of the current flight
  always_comb begin
    pp        = s2_r.pp_ok ? pp_rdata : '0;
    gb        = s2_r.gb_ok ? gb_rdata : '0;
    cur_e     = SUM_W'(cur_r);
    gb_e      = SUM_W'(gb);
    trimmed   = (cur_e > gb_e) ? (cur_e - gb_e) : '0;
    ext       = trimmed + SUM_W'(pp) + SUM_W'(pdgd_r);
    fits      = (ext <= SUM_W'(max_flight_time));
    ext_sat   = (ext > SUM_W'(FT_MAX)) ? FT_MAX : ext[FT_W-1:0];
    fresh_e   = SUM_W'(fresh_r);
    fresh_sat = (fresh_e > SUM_W'(FT_MAX)) ? FT_MAX : fresh_e[FT_W-1:0];
    sum_wide  = {1'b0, closed_r} + (TOT_W + 1)'(cur_r);
    sum_sat   = sum_wide[TOT_W] ? TOT_MAX : sum_wide[TOT_W-1:0];
  end

  always_comb begin
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    mcnt_nxt     = mcnt_r;
    fcnt_nxt     = fcnt_r;
    closed_nxt   = closed_r;
    active_nxt   = active_r;
    out_kind_nxt = KIND_MISSION;
    out_mi_nxt   = '0;
    out_fi_nxt   = '0;
    out_open_nxt = 1'b0;
    out_ft_nxt   = '0;
    out_tot_nxt  = '0;
    if (s2_r.is_finish) begin
      out_kind_nxt = KIND_SUMMARY;
      out_tot_nxt  = active_r ? sum_sat : '0;
      cur_nxt      = '0;
      prev_nxt     = '0;
      mcnt_nxt     = '0;
      fcnt_nxt     = '0;
      closed_nxt   = '0;
      active_nxt   = 1'b0;
    end else begin
      priority if (!active_r) begin
        cur_nxt      = fresh_sat;
        fcnt_nxt     = '0;
        out_open_nxt = 1'b1;
      end else if (fits) begin
        cur_nxt      = ext_sat;
      end else begin
        // flight closes, new one starts with a fresh round trip
        closed_nxt   = sum_sat;
        fcnt_nxt     = (fcnt_r == CNT_MAX) ? fcnt_r : fcnt_r + 1'b1;
        cur_nxt      = fresh_sat;
        out_open_nxt = 1'b1;
      end
      prev_nxt   = s2_r.delivery;
      active_nxt = 1'b1;
      mcnt_nxt   = (mcnt_r == CNT_MAX) ? mcnt_r : mcnt_r + 1'b1;
      out_mi_nxt = mcnt_r;
      out_fi_nxt = fcnt_nxt;
      out_ft_nxt = cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      prev_r   <= '0;
      mcnt_r   <= '0;
      fcnt_r   <= '0;
      closed_r <= '0;
      active_r <= 1'b0;
    end else if (s2_go) begin
      cur_r    <= cur_nxt;
      prev_r   <= prev_nxt;
      mcnt_r   <= mcnt_nxt;
      fcnt_r   <= fcnt_nxt;
      closed_r <= closed_nxt;
      active_r <= active_nxt;
    end
  end

  // result register
  always_comb begin
    priority if (s2_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_kind_r <= out_kind_nxt;
      out_mi_r   <= out_mi_nxt;
      out_fi_r   <= out_fi_nxt;
      out_open_r <= out_open_nxt;
      out_ft_r   <= out_ft_nxt;
      out_tot_r  <= out_tot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {2'b00, out_tot_r, out_ft_r, out_open_r, out_fi_r, out_mi_r};

  // a stalled entry stays in the stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_stall |=> s2_r.valid)
    else $error("update stage entry lost while stalled");

  // a finish leaves a cleared session
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_r.is_finish) |=> (!active_r && mcnt_r == '0 && closed_r == '0))
    else $error("session not cleared by finish");

  // a mission opens the session and records its delivery node
  a_mission_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && !s2_r.is_finish) |=> (active_r && prev_r == $past(s2_r.delivery)))
    else $error("mission did not update session state");

endmodule

/* rtl/greedy_flight_partitioner.sv */
// top level of the greedy flight partitioner: input stage, distance memories, update stage
//
// Groups pickup/delivery missions into flights next-fit. Load items (tuser 0 and 1)
// write the node-to-node and node-to-ground distance memories and give no result.
// For a mission item (tuser 2) the single read port of the node-to-node memory
// is used twice, first for the pickup-to-delivery leg (together with both ground
// legs of the fresh round trip) and then for the leg from the previous delivery
// to the new pickup (together with the old return leg). The decision and the
// state update follow in the update stage, overlapping the next item's first
// read. A finish item (tuser 3) also passes through the first stage and returns
// the saturated total of all flight times, then clears the session; the distance
// memories keep their contents. Any item that follows a mission or finish waits
// until that item has left the first stage. Results sit in an output register,
// so a new item is taken while the previous result is still waiting. Distance
// memory entries have no reset and must be loaded before a mission reads them.
// The user must write max_flight_time through the cfg port while the block is
// idle; the block does not enforce this. It resets to its largest value.
module greedy_flight_partitioner #(
  parameter int NODE_COUNT    = 64,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: max_flight_time
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gfp_pkg::MAXFT_W-1:0]        cfg_data,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gfp_pkg::MODE_W-1:0]         in_tuser,   // mode
  // from_node, to_node, distance_value, pickup_node, delivery_node
  input  logic [gfp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tuser,  // result_kind
  // mission_index, flight_index, opened_new_flight, flight_time, total_time, zero pad
  output logic [gfp_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import gfp_pkg::*;

  localparam int DW     = DISTANCE_BITS;
  localparam int SW1    = DW + 1;
  localparam int SW2    = DW + 2;
  localparam int GAW    = $clog2(NODE_COUNT);
  localparam int PDEPTH = NODE_COUNT * NODE_COUNT;
  localparam int PAW    = $clog2(PDEPTH);

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (int'(n) < NODE_COUNT);
  endfunction

  function automatic logic [GAW-1:0] gidx(input logic [NODE_W-1:0] n);
    return GAW'(n);
  endfunction

  function automatic logic [PAW-1:0] pidx(input logic [NODE_W-1:0] a,
                                          input logic [NODE_W-1:0] b);
    return PAW'(gidx(a)) * PAW'(NODE_COUNT) + PAW'(gidx(b));
  endfunction

  // input fields
  logic [NODE_W-1:0]    in_from;
  logic [NODE_W-1:0]    in_to;
  logic [DIST_IN_W-1:0] in_dist;
  logic [NODE_W-1:0]    in_pickup;
  logic [NODE_W-1:0]    in_delivery;

  assign in_from     = in_tdata[5:0];
  assign in_to       = in_tdata[11:6];
  assign in_dist     = in_tdata[27:12];
  assign in_pickup   = in_tdata[33:28];
  assign in_delivery = in_tdata[39:34];

  // configuration register
  logic [MAXFT_W-1:0] max_ft_r, max_ft_nxt;

  assign cfg_ready  = 1'b1;
  assign max_ft_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_ft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ft_r <= MAXFT_RESET;
    end else begin
      max_ft_r <= max_ft_nxt;
    end
  end

  // handshake and item decode
  logic s2_stall;
  logic accept;
  logic acc_mission;
  logic acc_pipe;

  // first stage: waits for the first round of reads
  logic              s1_valid_r,  s1_valid_nxt;
  logic              s1_finish_r, s1_finish_nxt;
  logic [NODE_W-1:0] s1_p_r,      s1_p_nxt;
  logic [NODE_W-1:0] s1_d_r,      s1_d_nxt;
  logic              s1_adv;
  logic              adv_mission;

  logic [NODE_W-1:0] prev_node;

  // a mission or finish in the first stage blocks the input until it moves on
  assign in_tready   = !s1_valid_r && !s2_stall;
  assign accept      = in_tvalid && in_tready;
  assign acc_mission = accept && (in_tuser == MODE_MISSION);
  assign acc_pipe    = accept && ((in_tuser == MODE_MISSION) || (in_tuser == MODE_FINISH));
  assign s1_adv      = s1_valid_r && !s2_stall;
  assign adv_mission = s1_adv && !s1_finish_r;

  always_comb begin
    s1_finish_nxt = s1_finish_r;
    s1_p_nxt      = s1_p_r;
    s1_d_nxt      = s1_d_r;
    priority if (acc_pipe) begin
      s1_valid_nxt  = 1'b1;
      s1_finish_nxt = (in_tuser == MODE_FINISH);
      s1_p_nxt      = in_pickup;
      s1_d_nxt      = in_delivery;
    end else if (s1_adv) begin
      s1_valid_nxt  = 1'b0;
    end else begin
      s1_valid_nxt  = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_finish_r <= s1_finish_nxt;
    s1_p_r      <= s1_p_nxt;
    s1_d_r      <= s1_d_nxt;
  end

  // distance memories
  logic           pair_we;
  logic           ground_we;
  logic [DW-1:0]  wdata;
  logic           pair_re;
  logic [PAW-1:0] pair_raddr;
  logic [DW-1:0]  pair_rdata;
  logic           ga_re;
  logic [GAW-1:0] ga_raddr;
  logic [DW-1:0]  ga_rdata;
  logic [DW-1:0]  gb_rdata;

  // out-of-range loads are dropped
  assign pair_we   = accept && (in_tuser == MODE_PAIR_LOAD) && node_ok(in_from) && node_ok(in_to);
  assign ground_we = accept && (in_tuser == MODE_GROUND_LOAD) && node_ok(in_from);
  assign wdata     = DW'(in_dist);

  // first round on transfer, second round when the mission leaves the first stage
  assign pair_re    = acc_mission || adv_mission;
  assign pair_raddr = s1_valid_r ? pidx(prev_node, s1_p_r) : pidx(in_pickup, in_delivery);
  assign ga_re      = acc_mission || adv_mission;
  assign ga_raddr   = s1_valid_r ? gidx(prev_node) : gidx(in_pickup);

  gfp_pair_mem #(
    .DEPTH  (PDEPTH),
    .ADDR_W (PAW),
    .DATA_W (DW)
  ) u_pair_mem (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pidx(in_from, in_to)),
    .wdata (wdata),
    .re    (pair_re),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  gfp_ground_mem #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (GAW),
    .DATA_W (DW)
  ) u_ground_mem (
    .clk     (clk),
    .we      (ground_we),
    .waddr   (gidx(in_from)),
    .wdata   (wdata),
    .re_a    (ga_re),
    .raddr_a (ga_raddr),
    .rdata_a (ga_rdata),
    .re_b    (acc_mission),
    .raddr_b (gidx(in_delivery)),
    .rdata_b (gb_rdata)
  );

  // fresh round trip from the first round of reads; out-of-range nodes read as zero
  logic          p_ok;
  logic          d_ok;
  logic          prev_ok;
  logic [DW-1:0] gp;
  logic [DW-1:0] pd;
  logic [DW-1:0] gd;
  logic [DW:0]   pdgd;
  logic [DW+1:0] fresh;
  s2_entry_t     s2_in;

  always_comb begin
    p_ok    = node_ok(s1_p_r);
    d_ok    = node_ok(s1_d_r);
    prev_ok = node_ok(prev_node);
    gp      = p_ok ? ga_rdata : '0;
    pd      = (p_ok && d_ok) ? pair_rdata : '0;
    gd      = d_ok ? gb_rdata : '0;
    pdgd    = SW1'(pd) + SW1'(gd);
    fresh   = SW2'(gp) + SW2'(pdgd);
    s2_in.valid     = s1_adv;
    s2_in.is_finish = s1_finish_r;
    s2_in.pp_ok     = prev_ok && p_ok;
    s2_in.gb_ok     = prev_ok;
    s2_in.delivery  = s1_d_r;
  end

  gfp_flight_core #(
    .DIST_W (DW)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_flight_time (max_ft_r),
    .s2_in           (s2_in),
    .fresh_in        (fresh),
    .pdgd_in         (pdgd),
    .pp_rdata        (pair_rdata),
    .gb_rdata        (ga_rdata),
    .s2_stall        (s2_stall),
    .prev_node       (prev_node),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tuser       (out_tuser),
    .out_tdata       (out_tdata)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench of the greedy flight partitioner: directed and random items checked against a predictor
module testbench;
  import gfp_pkg::*;

  localparam int NODES         = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int HOT_COUNT     = 10;

  // one expected result, fields as they travel on the result channel
  typedef struct {
    kind_t              kind;
    bit [CNT_W-1:0]     mission_index;
    bit [CNT_W-1:0]     flight_index;
    bit                 opened;
    bit [FT_W-1:0]      ftime;
    bit [TOT_W-1:0]     total_time;
  } flight_result_t;

  // mirror of the distance memories and the session, plus the queue of pending results
  class flight_ledger;
    bit [DIST_IN_W-1:0] pair_dist    [NODES*NODES];
    bit                 pair_known   [NODES*NODES];
    bit [DIST_IN_W-1:0] ground_dist  [NODES];
    bit                 ground_known [NODES];
    bit [FT_W-1:0]      run_time;
    bit [NODE_W-1:0]    last_delivery;
    bit [CNT_W-1:0]     mission_count;
    bit [CNT_W-1:0]     flight_count;
    bit [TOT_W-1:0]     closed_sum;
    bit                 active;
    bit [MAXFT_W-1:0]   max_time;
    flight_result_t     awaited[$];
    int                 mismatches;

    function new();
      max_time   = MAXFT_RESET;
      mismatches = 0;
      clear_session();
    endfunction

    function void clear_session();
      run_time      = '0;
      last_delivery = '0;
      mission_count = '0;
      flight_count  = '0;
      closed_sum    = '0;
      active        = 1'b0;
    endfunction

    function void set_limit(bit [MAXFT_W-1:0] value);
      max_time = value;
    endfunction

    function bit [FT_W-1:0] clamp_ft(longint unsigned v);
      return (v > longint'(FT_MAX)) ? FT_MAX : v[FT_W-1:0];
    endfunction

    // predict the effect of one accepted input transfer
    function void note_item(mode_t mode, bit [IN_TDATA_W-1:0] data);
      bit [NODE_W-1:0]    from_n;
      bit [NODE_W-1:0]    to_n;
      bit [DIST_IN_W-1:0] dval;
      bit [NODE_W-1:0]    pick;
      bit [NODE_W-1:0]    drop;
      longint unsigned    fresh;
      longint unsigned    ext;
      longint unsigned    back;
      longint unsigned    sum;
      flight_result_t     res;
      from_n = data[5:0];
      to_n   = data[11:6];
      dval   = data[27:12];
      pick   = data[33:28];
      drop   = data[39:34];
      case (mode)
        MODE_PAIR_LOAD: begin
          pair_dist[from_n*NODES+to_n]  = dval;
          pair_known[from_n*NODES+to_n] = 1'b1;
        end
        MODE_GROUND_LOAD: begin
          ground_dist[from_n]  = dval;
          ground_known[from_n] = 1'b1;
        end
        MODE_FINISH: begin
          sum = 0;
          if (active) begin
            sum = longint'(closed_sum) + longint'(run_time);
            if (sum > longint'(TOT_MAX)) sum = longint'(TOT_MAX);
          end
          res = '{KIND_SUMMARY, '0, '0, 1'b0, '0, sum[TOT_W-1:0]};
          awaited = {awaited, res};
          clear_session();
        end
        default: begin
          fresh = longint'(ground_dist[pick]) + longint'(pair_dist[pick*NODES+drop])
                  + longint'(ground_dist[drop]);
          if (!active) begin
            active       = 1'b1;
            flight_count = '0;
            run_time     = clamp_ft(fresh);
            res.opened   = 1'b1;
          end else begin
            // drop the old return leg, floored at zero
            back = longint'(ground_dist[last_delivery]);
            ext  = (longint'(run_time) > back) ? longint'(run_time) - back : 0;
            ext += longint'(pair_dist[last_delivery*NODES+pick])
                   + longint'(pair_dist[pick*NODES+drop]) + longint'(ground_dist[drop]);
            if (ext <= longint'(max_time)) begin
              run_time    = clamp_ft(ext);
              res.opened  = 1'b0;
            end else begin
              sum        = longint'(closed_sum) + longint'(run_time);
              closed_sum = (sum > longint'(TOT_MAX)) ? TOT_MAX : sum[TOT_W-1:0];
              if (flight_count != CNT_MAX) flight_count++;
              run_time    = clamp_ft(fresh);
              res.opened  = 1'b1;
            end
          end
          last_delivery     = drop;
          res.kind          = KIND_MISSION;
          res.mission_index = mission_count;
          res.flight_index  = flight_count;
          res.ftime         = run_time;
          res.total_time    = '0;
          awaited = {awaited, res};
          if (mission_count != CNT_MAX) mission_count++;
        end
      endcase
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %0d, got %0d", what, want, got);
    endfunction

    // compare one accepted result with the oldest pending one
    function void check_result(bit kind, bit [OUT_TDATA_W-1:0] data);
      flight_result_t want;
      if (awaited.size() == 0) begin
        flag("result with nothing pending, result_kind", 0, kind);
        return;
      end
      want = awaited.pop_front();
      if (kind != want.kind) flag("result_kind", want.kind, kind);
      if (data[15:0] != want.mission_index) flag("mission_index", want.mission_index, data[15:0]);
      if (data[31:16] != want.flight_index) flag("flight_index", want.flight_index, data[31:16]);
      if (data[32] != want.opened) flag("opened_new_flight", want.opened, data[32]);
      if (data[53:33] != want.ftime) flag("flight time", want.ftime, data[53:33]);
      if (data[85:54] != want.total_time) flag("total_time", want.total_time, data[85:54]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [MAXFT_W-1:0]     cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [MODE_W-1:0]      in_tuser;   // mode
  // from_node, to_node, distance_value, pickup_node, delivery_node
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   out_tuser;  // result_kind
  // mission_index, flight_index, opened_new_flight, flight_time, total_time, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;

  flight_ledger ledger = new();

  int burst_left = 1;
  int items_sent = 0;
  int ready_left = 0;
  int cycles     = 0;
  int hot_nodes [HOT_COUNT];

  greedy_flight_partitioner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: ready and stall stretches of random length, now and then a long ready stretch
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_tready <= 1'b0;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_left = $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 15);
    end
  end

  // every result transfer is checked against the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      ledger.check_result(out_tuser, out_tdata);
  end

  // generous guard on the run length
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("greedy_flight_partitioner: mismatch");
    $finish;
  end

  // mostly full-range distances, with short ones so that flights grow over several missions and extremes mixed in
  function automatic bit [DIST_IN_W-1:0] rand_dist();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DIST_IN_W'($urandom_range(0, 3000));
      default: return DIST_IN_W'($urandom);
    endcase
  endfunction

  function automatic bit [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 99) < 85) return NODE_W'(hot_nodes[$urandom_range(0, HOT_COUNT-1)]);
    return NODE_W'($urandom_range(0, NODES-1));
  endfunction

  // one input transfer; valid stays high inside a burst, a gap follows each burst
  task automatic send_item(mode_t mode, bit [NODE_W-1:0] from_n, bit [NODE_W-1:0] to_n,
                           bit [DIST_IN_W-1:0] dval, bit [NODE_W-1:0] pick,
                           bit [NODE_W-1:0] drop);
    bit [IN_TDATA_W-1:0] item;
    item = {drop, pick, dval, to_n, from_n};
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.note_item(mode, item);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
    end
  endtask

  task automatic load_pair(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b, bit [DIST_IN_W-1:0] dval);
    send_item(MODE_PAIR_LOAD, a, b, dval, NODE_W'($urandom), NODE_W'($urandom));
  endtask

  task automatic load_ground(bit [NODE_W-1:0] a, bit [DIST_IN_W-1:0] dval);
    send_item(MODE_GROUND_LOAD, a, NODE_W'($urandom), dval, NODE_W'($urandom),
              NODE_W'($urandom));
  endtask

  task automatic finish_session();
    send_item(MODE_FINISH, NODE_W'($urandom), NODE_W'($urandom), DIST_IN_W'($urandom),
              NODE_W'($urandom), NODE_W'($urandom));
  endtask

  // a mission only ever reads loaded entries: missing legs are loaded first
  task automatic fly_mission(bit [NODE_W-1:0] pick, bit [NODE_W-1:0] drop);
    if (!ledger.ground_known[pick]) load_ground(pick, rand_dist());
    if (!ledger.pair_known[pick*NODES+drop]) load_pair(pick, drop, rand_dist());
    if (!ledger.ground_known[drop]) load_ground(drop, rand_dist());
    if (ledger.active && !ledger.pair_known[ledger.last_delivery*NODES+pick])
      load_pair(ledger.last_delivery, pick, rand_dist());
    send_item(MODE_MISSION, NODE_W'($urandom), NODE_W'($urandom), DIST_IN_W'($urandom),
              pick, drop);
  endtask

  // drop valid, let every pending result arrive and trailing loads settle
  task automatic drain();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_flight_time(bit [MAXFT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.set_limit(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [MAXFT_W-1:0] limits [6];
    int               target;
    int               roll;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_tvalid  <= 1'b0;
    in_tuser   <= '0;
    in_tdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: finish before any mission, extremes of nodes and distances
    finish_session();
    load_ground(6'd0, 16'd0);
    load_ground(6'd63, 16'hFFFF);
    load_pair(6'd0, 6'd63, 16'hFFFF);
    load_pair(6'd63, 6'd0, 16'd1);
    load_pair(6'd63, 6'd63, 16'd0);
    fly_mission(6'd0, 6'd63);   // first mission opens flight 0
    fly_mission(6'd63, 6'd0);   // extension within the limit
    finish_session();
    // old return leg raised above the flight time: the subtraction floors at zero
    load_ground(6'd1, 16'd5);
    load_pair(6'd1, 6'd1, 16'd0);
    fly_mission(6'd1, 6'd1);
    load_ground(6'd1, 16'hFFFF);
    fly_mission(6'd1, 6'd1);
    finish_session();
    finish_session();
    // zero limit: fresh round trips above it still open flights, every extension closes
    set_max_flight_time('0);
    fly_mission(6'd0, 6'd63);
    fly_mission(6'd63, 6'd0);
    fly_mission(6'd0, 6'd63);
    finish_session();

    // random phases, each under its own limit
    limits[0] = MAXFT_RESET;
    limits[1] = MAXFT_W'(150000);
    limits[2] = '0;
    limits[3] = MAXFT_W'(300000);
    limits[4] = MAXFT_W'($urandom_range(0, 1048575));
    limits[5] = MAXFT_W'($urandom_range(60000, 250000));
    for (int ph = 0; ph < 6; ph++) begin
      set_max_flight_time(limits[ph]);
      hot_nodes[0] = 0;
      hot_nodes[1] = NODES - 1;
      for (int k = 2; k < HOT_COUNT; k++) hot_nodes[k] = $urandom_range(0, NODES-1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          load_pair(NODE_W'($urandom), NODE_W'($urandom), rand_dist());
        else if (roll < 7)
          load_ground(pick_node(), rand_dist());
        else if (roll < 13)
          finish_session();
        else
          fly_mission(pick_node(), pick_node());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
      $display("greedy_flight_partitioner: match");
    else
      $display("greedy_flight_partitioner: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/gfp_pkg.sv
rtl/gfp_pair_mem.sv
rtl/gfp_ground_mem.sv
rtl/gfp_flight_core.sv
rtl/greedy_flight_partitioner.sv
tb/testbench.sv
